// File: hdl/i2c_master_byte_engine_unit_macros.svh
// assertion macros used by the i2c master byte engine rtl
`ifndef I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define IMBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define IMBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/imbe_pkg.sv
// shared types and constants of the i2c master byte engine
`timescale 1ns / 1ps

package imbe_pkg;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PHASE_W = 16;
  localparam int unsigned STEP_W  = 3;
  localparam int unsigned BITC_W  = 4;

  localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_START = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd250;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // one classified request as it travels from the front to the back
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] write_byte;
    logic              send_ack;
    logic              scl_sample;
    logic              sda_sample;
  } req_t;

  // one result as held in the output register
  typedef struct packed {
    logic              scl_drive;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_byte;
    logic              ack_seen;
  } res_t;

endpackage

// File: hdl/imbe_ifs.sv
// request and result channel interfaces of the i2c master byte engine
`timescale 1ns / 1ps

interface imbe_in_if import imbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  kind;
  logic [BYTE_W-1:0] write_byte;
  logic              send_ack;
  logic              scl_sample;
  logic              sda_sample;

  modport source (output valid, kind, write_byte, send_ack, scl_sample, sda_sample,
                  input ready);
  modport sink (input valid, kind, write_byte, send_ack, scl_sample, sda_sample,
                output ready);
endinterface

interface imbe_out_if import imbe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              scl_drive;
  logic              sda_drive;
  logic              busy_res;
  logic              done_res;
  logic [BYTE_W-1:0] read_byte;
  logic              ack_seen;

  modport source (output valid, scl_drive, sda_drive, busy_res, done_res, read_byte,
                  ack_seen, input ready);
  modport sink (input valid, scl_drive, sda_drive, busy_res, done_res, read_byte,
                ack_seen, output ready);
endinterface

// File: hdl/imbe_front.sv
// front end: takes requests and classifies the command kind
`timescale 1ns / 1ps

module imbe_front import imbe_pkg::*; (
  imbe_in_if.sink in_ch,
  input  logic    q_full,
  output logic    q_push,
  output req_t    q_push_req
);

  logic kind_ok;

  // kinds outside start..read count as no command
  assign kind_ok = (in_ch.kind == CMD_START) || (in_ch.kind == CMD_STOP) ||
                   (in_ch.kind == CMD_WRITE) || (in_ch.kind == CMD_READ);

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    q_push_req.cmd        = kind_ok ? in_ch.kind : CMD_NONE;
    q_push_req.write_byte = in_ch.write_byte;
    q_push_req.send_ack   = in_ch.send_ack;
    q_push_req.scl_sample = in_ch.scl_sample;
    q_push_req.sda_sample = in_ch.sda_sample;
  end

endmodule

// File: hdl/imbe_queue.sv
// short request queue between front and back
`timescale 1ns / 1ps

module imbe_queue import imbe_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output req_t pop_req
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  req_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_req   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// File: hdl/imbe_back.sv
// back end: bus sequencer, phase timer and result register
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_unit_macros.svh"

module imbe_back import imbe_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [PHASE_W-1:0] cfg_wr_data,
  input  logic               q_not_empty,
  input  req_t               q_req,
  output logic               q_pop,
  imbe_out_if.source         out_ch
);

  logic [PHASE_W-1:0] phase_ticks_r;
  logic [CMD_W-1:0]   active_r, active_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [BITC_W-1:0]  bitc_r, bitc_nxt;
  logic [PHASE_W-1:0] delay_r, delay_nxt;
  logic [BYTE_W-1:0]  shift_r, shift_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               ack_seen_r, ack_seen_nxt;
  logic               ack_req_r, ack_req_nxt;
  logic [BYTE_W-1:0]  read_hold_r, read_hold_nxt;
  logic               done;
  logic [PHASE_W-1:0] phase_load;
  logic               out_valid_r;
  res_t               out_r;

  assign q_pop      = q_not_empty && (!out_valid_r || out_ch.ready);
  // a zero setting behaves as one tick per phase
  assign phase_load = (phase_ticks_r == '0) ? '0 : phase_ticks_r - 1'b1;

  always_comb begin
    active_nxt    = active_r;
    step_nxt      = step_r;
    bitc_nxt      = bitc_r;
    delay_nxt     = delay_r;
    shift_nxt     = shift_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    ack_seen_nxt  = ack_seen_r;
    ack_req_nxt   = ack_req_r;
    read_hold_nxt = read_hold_r;
    done          = 1'b0;

    // idle engine latches a new command, otherwise the command is dropped
    if (active_r == CMD_NONE && q_req.cmd != CMD_NONE) begin
      active_nxt  = q_req.cmd;
      step_nxt    = '0;
      bitc_nxt    = '0;
      delay_nxt   = '0;
      ack_req_nxt = q_req.send_ack;
      if (q_req.cmd == CMD_WRITE) begin
        shift_nxt = q_req.write_byte;
      end else if (q_req.cmd == CMD_READ) begin
        shift_nxt = '0;
      end
    end

    if (active_nxt != CMD_NONE) begin
      if (delay_nxt != '0) begin
        delay_nxt = delay_nxt - 1'b1;
      end else begin
        unique case (active_nxt)
          CMD_START: begin
            unique case (step_nxt)
              3'd0: begin sda_nxt = 1'b1; delay_nxt = phase_load; step_nxt = 3'd1; end
              3'd1: begin scl_nxt = 1'b1; delay_nxt = phase_load; step_nxt = 3'd2; end
              3'd2: begin sda_nxt = 1'b0; delay_nxt = phase_load; step_nxt = 3'd3; end
              3'd3: begin scl_nxt = 1'b0; delay_nxt = phase_load; step_nxt = 3'd4; end
              default: done = 1'b1;
            endcase
          end
          CMD_STOP: begin
            unique case (step_nxt)
              3'd0: begin sda_nxt = 1'b0; delay_nxt = phase_load; step_nxt = 3'd1; end
              3'd1: begin scl_nxt = 1'b1; delay_nxt = phase_load; step_nxt = 3'd2; end
              3'd2: begin sda_nxt = 1'b1; delay_nxt = phase_load; step_nxt = 3'd3; end
              default: done = 1'b1;
            endcase
          end
          CMD_WRITE: begin
            unique case (step_nxt)
              3'd0: begin
                if (bitc_nxt != '0) begin
                  scl_nxt = 1'b0;
                end
                if (!bitc_nxt[BITC_W-1]) begin
                  sda_nxt   = shift_nxt[BYTE_W-1];
                  shift_nxt = {shift_nxt[BYTE_W-2:0], 1'b0};
                end else begin
                  sda_nxt = 1'b1;
                end
                delay_nxt = phase_load;
                step_nxt  = 3'd1;
              end
              3'd1: begin
                scl_nxt = 1'b1;
                if (!bitc_nxt[BITC_W-1]) begin
                  bitc_nxt = bitc_nxt + 1'b1;
                  step_nxt = 3'd0;
                end else begin
                  step_nxt = 3'd2;
                end
                delay_nxt = phase_load;
              end
              3'd2: begin
                // ack sampled while scl is still high for the ack bit
                ack_seen_nxt = !q_req.sda_sample;
                scl_nxt      = 1'b0;
                delay_nxt    = phase_load;
                step_nxt     = 3'd3;
              end
              default: done = 1'b1;
            endcase
          end
          CMD_READ: begin
            unique case (step_nxt)
              3'd0: begin
                sda_nxt   = 1'b1;
                scl_nxt   = 1'b1;
                delay_nxt = phase_load;
                step_nxt  = 3'd1;
              end
              3'd1: begin
                // wait here while the slave stretches the clock
                if (q_req.scl_sample) begin
                  shift_nxt = {shift_nxt[BYTE_W-2:0], q_req.sda_sample};
                  scl_nxt   = 1'b0;
                  bitc_nxt  = bitc_nxt + 1'b1;
                  if (!bitc_nxt[BITC_W-1]) begin
                    step_nxt = 3'd2;
                  end else begin
                    sda_nxt  = !ack_req_nxt;
                    step_nxt = 3'd3;
                  end
                  delay_nxt = phase_load;
                end
              end
              3'd2: begin scl_nxt = 1'b1; delay_nxt = phase_load; step_nxt = 3'd1; end
              3'd3: begin scl_nxt = 1'b1; delay_nxt = phase_load; step_nxt = 3'd4; end
              3'd4: begin scl_nxt = 1'b0; delay_nxt = phase_load; step_nxt = 3'd5; end
              default: begin
                sda_nxt       = 1'b1;
                read_hold_nxt = shift_nxt;
                done          = 1'b1;
              end
            endcase
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          active_nxt = CMD_NONE;
          step_nxt   = '0;
          bitc_nxt   = '0;
          delay_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
    end else if (cfg_wr_en) begin
      phase_ticks_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= CMD_NONE;
      step_r      <= '0;
      bitc_r      <= '0;
      delay_r     <= '0;
      shift_r     <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_seen_r  <= 1'b0;
      ack_req_r   <= 1'b0;
      read_hold_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        active_r    <= active_nxt;
        step_r      <= step_nxt;
        bitc_r      <= bitc_nxt;
        delay_r     <= delay_nxt;
        shift_r     <= shift_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        ack_seen_r  <= ack_seen_nxt;
        ack_req_r   <= ack_req_nxt;
        read_hold_r <= read_hold_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r.scl_drive <= scl_nxt;
      out_r.sda_drive <= sda_nxt;
      out_r.busy_res  <= (active_nxt != CMD_NONE);
      out_r.done_res  <= done;
      out_r.read_byte <= read_hold_nxt;
      out_r.ack_seen  <= ack_seen_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_drive = out_r.scl_drive;
  assign out_ch.sda_drive = out_r.sda_drive;
  assign out_ch.busy_res  = out_r.busy_res;
  assign out_ch.done_res  = out_r.done_res;
  assign out_ch.read_byte = out_r.read_byte;
  assign out_ch.ack_seen  = out_r.ack_seen;

  `IMBE_ASSERT_IMP(a_idle_clean, active_r == CMD_NONE,
                   step_r == '0 && bitc_r == '0 && delay_r == '0,
                   "idle engine holds stale sequencer state")
  `IMBE_ASSERT_IMP(a_done_not_busy, out_valid_r && out_r.done_res, !out_r.busy_res,
                   "completing result still flagged busy")
  `IMBE_ASSERT_NXT(a_delay_countdown, q_pop && active_r != CMD_NONE && delay_r != '0,
                   delay_r == $past(delay_r) - 1'b1,
                   "phase timer did not count down by one")
  `IMBE_ASSERT_IMP(a_bit_range, active_r != CMD_NONE, bitc_r <= 4'd8,
                   "bit counter ran past the byte")

endmodule

// File: hdl/i2c_master_byte_engine_unit.sv
// top level of the i2c master byte engine
`timescale 1ns / 1ps
// usage:
//   in_ch carries one request per bus-timer tick: kind (none, start, stop,
//   write byte, read byte), the byte to write, the ack choice for a read and
//   the sampled scl/sda levels. out_ch returns one result per request: the
//   scl/sda drive levels, busy, a one-tick done pulse, the last read byte and
//   the last write ack.
//   cfg_wr_en/cfg_wr_data set the ticks per bus phase (reset 250); write it
//   only while no request is in flight.
// path and throughput:
//   a request is held in the request queue and then in the output register
//   before its result can be taken on out_ch. one request is taken every
//   cycle while the queue has room; the sequencer finishes a tick's whole
//   step combinationally.
// reset:
//   rst_n is synchronous, active low; the engine goes idle with both lines
//   released, the queue empties and the phase setting returns to 250.
// stalls:
//   with a result waiting and out_ch.ready low, the result register holds,
//   the sequencer stops and requests queue up; in_ch.ready drops once full.

module i2c_master_byte_engine_unit import imbe_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  imbe_in_if.sink            in_ch,
  imbe_out_if.source         out_ch,
  input  logic               cfg_wr_en,
  input  logic [PHASE_W-1:0] cfg_wr_data
);

  // front to queue
  logic q_push;
  req_t q_push_req;
  logic q_full;
  // queue to back
  logic q_pop;
  logic q_not_empty;
  req_t q_pop_req;

  // classify kinds and take requests while the queue has room
  imbe_front u_front (
    .in_ch      (in_ch),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_req (q_push_req)
  );

  // short queue lets the front keep taking while the back waits on out_ch
  imbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_req  (q_push_req),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_req   (q_pop_req)
  );

  // bus sequencer: one tick per popped request
  imbe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_not_empty (q_not_empty),
    .q_req       (q_pop_req),
    .q_pop       (q_pop),
    .out_ch      (out_ch)
  );

endmodule

// File: dv/i2c_master_byte_engine_unit_test.sv
// self-checking testbench for the i2c master byte engine: tick predictor plus random bus traffic
`timescale 1ns / 1ps

module i2c_master_byte_engine_unit_test;
  import imbe_pkg::*;

  localparam int unsigned HALF_PERIOD   = 10;
  // no request or result moving for this long means the block is hung
  localparam int unsigned STALL_LIMIT   = 20000;
  // long receiver hold-off so the request queue fills and in_ch.ready drops
  localparam int unsigned HOLD_CYCLES   = 400;
  // counted ticks per random traffic phase, four phases in all
  localparam int unsigned TRAFFIC_TICKS = 170;
  // ticks run into a stop at the longest phase setting
  localparam int unsigned LONG_PHASE_TICKS = 20;
  localparam int unsigned MAX_REPORTS   = 10;

  // kinds the engine must treat as no command
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  // tick-level copy of the engine plus the bus levels still owed by the block
  class bus_tick_scoreboard;
    logic [PHASE_W-1:0] phase_ticks;
    logic [CMD_W-1:0]   active_cmd;
    logic [STEP_W-1:0]  step;
    logic [BITC_W-1:0]  bit_cnt;
    logic [PHASE_W-1:0] delay_cnt;
    logic [BYTE_W-1:0]  shifter;
    logic               scl_lv;
    logic               sda_lv;
    logic               ack_seen;
    logic               ack_choice;
    logic [BYTE_W-1:0]  last_read;
    res_t               due_levels[$];
    int unsigned        fault_count;

    function new();
      phase_ticks = PHASE_TICKS_RESET;
      active_cmd  = CMD_NONE;
      step        = '0;
      bit_cnt     = '0;
      delay_cnt   = '0;
      shifter     = '0;
      scl_lv      = 1'b1;
      sda_lv      = 1'b1;
      ack_seen    = 1'b0;
      ack_choice  = 1'b0;
      last_read   = '0;
      fault_count = 0;
    endfunction

    function bit engine_idle();
      return active_cmd == CMD_NONE;
    endfunction

    // zero ticks per phase behaves as one
    function void next_phase(logic [STEP_W-1:0] s);
      delay_cnt = (phase_ticks == '0) ? '0 : phase_ticks - 1'b1;
      step = s;
    endfunction

    function res_t advance_bus_tick(req_t r);
      res_t e;
      bit   done;
      done = 1'b0;
      // commands only land on an idle engine; busy and completing ticks drop them
      if (active_cmd == CMD_NONE && r.cmd >= CMD_START && r.cmd <= CMD_READ) begin
        active_cmd = r.cmd;
        step       = '0;
        bit_cnt    = '0;
        delay_cnt  = '0;
        if (r.cmd == CMD_WRITE)
          shifter = r.write_byte;
        else if (r.cmd == CMD_READ)
          shifter = '0;
        ack_choice = r.send_ack;
      end
      if (active_cmd != CMD_NONE) begin
        if (delay_cnt != '0) begin
          delay_cnt = delay_cnt - 1'b1;
        end else begin
          case (active_cmd)
            CMD_START: begin
              case (step)
                0: begin sda_lv = 1'b1; next_phase(1); end
                1: begin scl_lv = 1'b1; next_phase(2); end
                2: begin sda_lv = 1'b0; next_phase(3); end
                3: begin scl_lv = 1'b0; next_phase(4); end
                default: done = 1'b1;
              endcase
            end
            CMD_STOP: begin
              case (step)
                0: begin sda_lv = 1'b0; next_phase(1); end
                1: begin scl_lv = 1'b1; next_phase(2); end
                2: begin sda_lv = 1'b1; next_phase(3); end
                default: done = 1'b1;
              endcase
            end
            CMD_WRITE: begin
              case (step)
                0: begin
                  if (bit_cnt != '0) scl_lv = 1'b0;
                  if (bit_cnt < BYTE_W) begin
                    sda_lv  = shifter[BYTE_W-1];
                    shifter = shifter << 1;
                  end else begin
                    sda_lv = 1'b1;
                  end
                  next_phase(1);
                end
                1: begin
                  scl_lv = 1'b1;
                  if (bit_cnt < BYTE_W) begin
                    bit_cnt = bit_cnt + 1'b1;
                    next_phase(0);
                  end else begin
                    next_phase(2);
                  end
                end
                2: begin
                  // ack taken while scl is still high for the ack bit
                  ack_seen = ~r.sda_sample;
                  scl_lv   = 1'b0;
                  next_phase(3);
                end
                default: done = 1'b1;
              endcase
            end
            CMD_READ: begin
              case (step)
                0: begin sda_lv = 1'b1; scl_lv = 1'b1; next_phase(1); end
                1: begin
                  // slave stretching scl: retry every tick until it is released
                  if (r.scl_sample) begin
                    shifter = {shifter[BYTE_W-2:0], r.sda_sample};
                    scl_lv  = 1'b0;
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt < BYTE_W) begin
                      next_phase(2);
                    end else begin
                      sda_lv = ~ack_choice;
                      next_phase(3);
                    end
                  end
                end
                2: begin scl_lv = 1'b1; next_phase(1); end
                3: begin scl_lv = 1'b1; next_phase(4); end
                4: begin scl_lv = 1'b0; next_phase(5); end
                default: begin
                  sda_lv    = 1'b1;
                  last_read = shifter;
                  done      = 1'b1;
                end
              endcase
            end
            default: done = 1'b1;
          endcase
          if (done) begin
            active_cmd = CMD_NONE;
            step       = '0;
            bit_cnt    = '0;
            delay_cnt  = '0;
          end
        end
      end
      e.scl_drive = scl_lv;
      e.sda_drive = sda_lv;
      e.busy_res  = (active_cmd != CMD_NONE);
      e.done_res  = done;
      e.read_byte = last_read;
      e.ack_seen  = ack_seen;
      return e;
    endfunction

    function void take_request(req_t r);
      due_levels.push_back(advance_bus_tick(r));
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (due_levels.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: result with nothing expected: %p", $realtime, got);
        return;
      end
      want = due_levels.pop_front();
      if (got.scl_drive !== want.scl_drive || got.sda_drive !== want.sda_drive ||
          got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
          got.read_byte !== want.read_byte || got.ack_seen !== want.ack_seen) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [PHASE_W-1:0] cfg_wr_data;

  imbe_in_if  in_ch ();
  imbe_out_if out_ch ();

  i2c_master_byte_engine_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  bus_tick_scoreboard bus_model = new();

  // idling controls for the request driver and the result taker
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;
  // command sequence of the transfer being played out
  req_t        planned_cmds[$];

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // random command with random payload; bus samples are filled in per tick
  function automatic req_t make_cmd(logic [CMD_W-1:0] k);
    req_t r;
    r.cmd        = k;
    r.write_byte = BYTE_W'($urandom_range(255));
    r.send_ack   = ($urandom_range(1) != 0);
    r.scl_sample = 1'b1;
    r.sda_sample = 1'b1;
    return r;
  endfunction

  // offer one request at a falling edge, wait for it to be taken, predict its result
  task automatic send_tick(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= r.cmd;
    in_ch.write_byte <= r.write_byte;
    in_ch.send_ack   <= r.send_ack;
    in_ch.scl_sample <= r.scl_sample;
    in_ch.sda_sample <= r.sda_sample;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    bus_model.take_request(r);
    @(negedge clk);
  endtask

  // one command, then plain ticks until the engine is idle again
  // stretch holds scl low on the first ticks; poke throws random kinds at the busy engine
  task automatic finish_cmd(input logic [CMD_W-1:0] k, input logic [BYTE_W-1:0] b,
                            input logic a, input logic sda, input int unsigned stretch,
                            input bit poke);
    req_t r;
    r.cmd        = k;
    r.write_byte = b;
    r.send_ack   = a;
    r.scl_sample = 1'b1;
    r.sda_sample = sda;
    send_tick(r);
    while (!bus_model.engine_idle()) begin
      r.cmd        = poke ? CMD_W'($urandom_range(7)) : CMD_NONE;
      r.scl_sample = (stretch == 0);
      if (stretch != 0) stretch--;
      send_tick(r);
    end
  endtask

  // mostly well-formed transfers (start, address, data bytes, stop) with noise mixed in
  task automatic run_traffic(input int unsigned n_ticks);
    req_t        r;
    req_t        p;
    int unsigned counted;
    int unsigned stretch;
    counted = 0;
    stretch = 0;
    while (counted < n_ticks || !bus_model.engine_idle()) begin
      r = make_cmd(CMD_NONE);
      r.sda_sample = ($urandom_range(1) != 0);
      // occasional long clock stretch bursts, otherwise scl mostly released
      if (stretch == 0 && $urandom_range(49) == 0) stretch = $urandom_range(15, 4);
      if (stretch != 0) begin
        r.scl_sample = 1'b0;
        stretch--;
      end else begin
        r.scl_sample = ($urandom_range(3) != 0);
      end
      if (counted >= n_ticks) begin
        // wind down the command in flight
        r.scl_sample = 1'b1;
      end else if (bus_model.engine_idle()) begin
        if (planned_cmds.size() == 0) begin
          planned_cmds.push_back(make_cmd(CMD_START));
          planned_cmds.push_back(make_cmd(CMD_WRITE));
          repeat ($urandom_range(3, 1))
            planned_cmds.push_back(make_cmd($urandom_range(1) ? CMD_WRITE : CMD_READ));
          // repeated start into a read
          if ($urandom_range(4) == 0) begin
            planned_cmds.push_back(make_cmd(CMD_START));
            planned_cmds.push_back(make_cmd(CMD_WRITE));
            planned_cmds.push_back(make_cmd(CMD_READ));
          end
          // now and then the stop is left out
          if ($urandom_range(9) != 0)
            planned_cmds.push_back(make_cmd(CMD_STOP));
        end
        if ($urandom_range(99) < 88) begin
          p = planned_cmds.pop_front();
          r.cmd        = p.cmd;
          r.write_byte = p.write_byte;
          r.send_ack   = p.send_ack;
        end else begin
          r.cmd = CMD_W'($urandom_range(7));
        end
      end else begin
        // commands against a busy engine are dropped
        r.cmd = ($urandom_range(9) == 0) ? CMD_W'($urandom_range(7)) : CMD_NONE;
      end
      if (counted < n_ticks &&
          (!bus_model.engine_idle() || (r.cmd >= CMD_START && r.cmd <= CMD_READ)))
        counted++;
      send_tick(r);
    end
  endtask

  // phase setting only changes with no request in flight
  task automatic set_phase_ticks(input logic [PHASE_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (bus_model.due_levels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    bus_model.phase_ticks = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // result taker: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // results are compared on the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      res_t got;
      got.scl_drive = out_ch.scl_drive;
      got.sda_drive = out_ch.sda_drive;
      got.busy_res  = out_ch.busy_res;
      got.done_res  = out_ch.done_res;
      got.read_byte = out_ch.read_byte;
      got.ack_seen  = out_ch.ack_seen;
      bus_model.check_result(got);
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = CMD_NONE;
    in_ch.write_byte = '0;
    in_ch.send_ack   = 1'b0;
    in_ch.scl_sample = 1'b1;
    in_ch.sda_sample = 1'b1;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    hold_req         = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // a stop at the reset phase setting of 250 ticks
    finish_cmd(CMD_STOP, 8'h00, 1'b0, 1'b1, 0, 1'b0);

    // directed part, zero ticks per phase (runs as one)
    set_phase_ticks('0);
    finish_cmd(CMD_START, 8'hFF, 1'b1, 1'b0, 0, 1'b0);
    finish_cmd(CMD_WRITE, 8'h00, 1'b0, 1'b0, 0, 1'b0);   // slave acks
    finish_cmd(CMD_WRITE, 8'hFF, 1'b1, 1'b1, 0, 1'b0);   // slave nacks
    finish_cmd(CMD_WRITE, 8'hA5, 1'b0, 1'b0, 0, 1'b1);   // commands thrown at busy engine
    finish_cmd(CMD_READ, 8'h00, 1'b1, 1'b1, 0, 1'b0);    // all ones, master acks
    finish_cmd(CMD_READ, 8'hFF, 1'b0, 1'b0, 0, 1'b0);    // all zeros, master nacks
    finish_cmd(CMD_READ, 8'h5A, 1'b1, 1'b1, 7, 1'b1);    // clock stretched read
    finish_cmd(CMD_UNUSED_LO, 8'h3C, 1'b1, 1'b0, 0, 1'b0);
    finish_cmd(CMD_UNUSED_LO + 1'b1, 8'hC3, 1'b0, 1'b1, 0, 1'b0);
    finish_cmd(CMD_UNUSED_HI, 8'h81, 1'b1, 1'b0, 0, 1'b0);
    finish_cmd(CMD_NONE, 8'h7E, 1'b0, 1'b1, 0, 1'b0);
    finish_cmd(CMD_STOP, 8'h00, 1'b0, 1'b1, 0, 1'b0);
    finish_cmd(CMD_START, 8'h00, 1'b0, 1'b1, 0, 1'b0);
    finish_cmd(CMD_START, 8'h00, 1'b1, 1'b1, 0, 1'b0);   // repeated start
    finish_cmd(CMD_STOP, 8'h00, 1'b0, 1'b1, 0, 1'b1);

    // random traffic, no idling on either side
    set_phase_ticks(16'd1);
    run_traffic(TRAFFIC_TICKS);

    // sender idles often
    set_phase_ticks(16'd3);
    send_idle_pct = 76;
    run_traffic(TRAFFIC_TICKS);

    // receiver stalls often, with one long hold-off up front
    set_phase_ticks(16'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 76;
    hold_req       = 1'b1;
    run_traffic(TRAFFIC_TICKS);

    // both sides idle now and then
    set_phase_ticks(16'd5);
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    run_traffic(TRAFFIC_TICKS);

    // longest phase setting: a stop started and its first phase counted down a little
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_phase_ticks(16'hFFFF);
    send_tick(make_cmd(CMD_STOP));
    repeat (LONG_PHASE_TICKS) send_tick(make_cmd(CMD_NONE));

    in_ch.valid <= 1'b0;
    while (bus_model.due_levels.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bus_model.fault_count == 0 && bus_model.due_levels.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/imbe_pkg.sv
hdl/imbe_ifs.sv
hdl/imbe_front.sv
hdl/imbe_queue.sv
hdl/imbe_back.sv
hdl/i2c_master_byte_engine_unit.sv
dv/i2c_master_byte_engine_unit_test.sv
